// File: rtl/core/rfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types, codes and helpers of the rectangle raster engine.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_CLIP_DEPTH = 16;

  localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [31:0] RST_CLEAR_COLOR  = 32'hFFFF_FFFF;

  localparam logic [2:0] CMD_FILL    = 3'd0;
  localparam logic [2:0] CMD_STROKE  = 3'd1;
  localparam logic [2:0] CMD_SAVE    = 3'd2;
  localparam logic [2:0] CMD_RESTORE = 3'd3;
  localparam logic [2:0] CMD_CLIP    = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [2:0] K_FILL    = 3'd0;
  localparam logic [2:0] K_STROKE  = 3'd1;
  localparam logic [2:0] K_SAVE    = 3'd2;
  localparam logic [2:0] K_RESTORE = 3'd3;
  localparam logic [2:0] K_CLIP    = 3'd4;
  localparam logic [2:0] K_CLEAR   = 3'd5;
  localparam logic [2:0] K_READ    = 3'd6;
  localparam logic [2:0] K_NOP     = 3'd7;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_SAVE_FULL = 2'd1;
  localparam logic [1:0] ST_READ_OUT  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  localparam logic [11:0] MIN_STROKE = 12'd16;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [11:0]        stroke_size;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } entry_t;

  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [31:0] color;
  } cfg_t;

  function automatic logic [12:0] act_dim(input logic [8:0] v, input int mx);
    logic [12:0] r;
    if (v == 9'd0) r = 13'd1;
    else if (int'(v) > mx) r = 13'(mx);
    else r = 13'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rfr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_if
// Command and result channel interfaces.
// ----------------------------------------------------------------------------
interface rfr_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic [11:0]        stroke_size;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  modport source(output valid, command, rect_x, rect_y, rect_width, rect_height,
                 stroke_size, red, green, blue, alpha, input ready);
  modport sink(input valid, command, rect_x, rect_y, rect_width, rect_height,
               stroke_size, red, green, blue, alpha, output ready);
endinterface

interface rfr_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [1:0]  status;
  logic [4:0]  clip_depth;
  modport source(output valid, pixel_value, status, clip_depth, input ready);
  modport sink(input valid, pixel_value, status, clip_depth, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rect_fill_raster_with_clip_stack_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rect_fill_raster_with_clip_stack_unit
// Rectangle fill/stroke raster engine with clip stack and RGBA8 frame store.
// ----------------------------------------------------------------------------
// Fill walks each covered pixel, stroke each covered pixel of its four
//   bands; each pixel is read, blended and written back.
// Clear: MAX_WIDTH*MAX_HEIGHT frame words, one frame word written per cycle.
// Flow: one word at a time in the engine; a two-word queue takes input
//   while it works, and the next word starts while a result waits in its register.
// Reset: control, clip stack top and registers reset; frame store is not.
module rect_fill_raster_with_clip_stack_unit #(
  parameter int MAX_WIDTH  = rfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfr_pkg::DEF_MAX_HEIGHT,
  parameter int CLIP_DEPTH = rfr_pkg::DEF_CLIP_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rfr_cmd_if.sink          cmd,
  rfr_res_if.source        res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  rfr_pkg::cfg_t   cfg;
  logic            push_valid;
  logic            push_ready;
  rfr_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  rfr_pkg::entry_t pop_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= rfr_pkg::RST_IMAGE_WIDTH;
      cfg.height <= rfr_pkg::RST_IMAGE_HEIGHT;
      cfg.color  <= rfr_pkg::RST_CLEAR_COLOR;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rfr_pkg::REG_WIDTH:  cfg.width  <= pwdata[8:0];
        rfr_pkg::REG_HEIGHT: cfg.height <= pwdata[8:0];
        rfr_pkg::REG_COLOR:  cfg.color  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rfr_pkg::REG_WIDTH:  prdata = {23'd0, cfg.width};
      rfr_pkg::REG_HEIGHT: prdata = {23'd0, cfg.height};
      rfr_pkg::REG_COLOR:  prdata = cfg.color;
      default:             prdata = '0;
    endcase
  end

  rfr_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rfr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CLIP_DEPTH (CLIP_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (res)
  );
endmodule
`default_nettype wire

// File: rtl/core/rfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/rfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_front
// Command intake: decodes the command class and clamps the stroke width.
// ----------------------------------------------------------------------------
module rfr_front (
  rfr_cmd_if.sink              cmd,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output rfr_pkg::entry_t      push_data
);
  logic [2:0] kind;

  always_comb begin
    case (cmd.command)
      rfr_pkg::CMD_FILL:    kind = rfr_pkg::K_FILL;
      rfr_pkg::CMD_STROKE:  kind = rfr_pkg::K_STROKE;
      rfr_pkg::CMD_SAVE:    kind = rfr_pkg::K_SAVE;
      rfr_pkg::CMD_RESTORE: kind = rfr_pkg::K_RESTORE;
      rfr_pkg::CMD_CLIP:    kind = rfr_pkg::K_CLIP;
      rfr_pkg::CMD_CLEAR:   kind = rfr_pkg::K_CLEAR;
      rfr_pkg::CMD_READ:    kind = rfr_pkg::K_READ;
      default:              kind = rfr_pkg::K_NOP;
    endcase
  end

  always_comb begin
    push_data.kind         = kind;
    push_data.rect_x       = cmd.rect_x;
    push_data.rect_y       = cmd.rect_y;
    push_data.rect_width   = cmd.rect_width;
    push_data.rect_height  = cmd.rect_height;
    push_data.stroke_size  = (cmd.stroke_size < rfr_pkg::MIN_STROKE) ?
                             rfr_pkg::MIN_STROKE : cmd.stroke_size;
    push_data.red          = cmd.red;
    push_data.green        = cmd.green;
    push_data.blue         = cmd.blue;
    push_data.alpha        = cmd.alpha;
  end

  assign push_valid = cmd.valid;
  assign cmd.ready  = push_ready;
endmodule
`default_nettype wire

// File: rtl/core/rfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_queue
// Two-entry command queue between intake and raster engine.
// ----------------------------------------------------------------------------
module rfr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire rfr_pkg::entry_t  push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output rfr_pkg::entry_t       pop_data
);
  rfr_pkg::entry_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        slots[wp] <= push_data;
        wp        <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/rfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_back
// Raster engine: clip stack, pixel walk with read-blend-write, clear sweep,
// pixel read and the result register.
// ----------------------------------------------------------------------------
module rfr_back #(
  parameter int MAX_WIDTH  = rfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfr_pkg::DEF_MAX_HEIGHT,
  parameter int CLIP_DEPTH = rfr_pkg::DEF_CLIP_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rfr_pkg::cfg_t   cfg,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire rfr_pkg::entry_t pop_data,
  rfr_res_if.source            res
);
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int TW   = $clog2(CLIP_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RECT = 4'd1;
  localparam logic [3:0] S_PRD  = 4'd2;
  localparam logic [3:0] S_PMUL = 4'd3;
  localparam logic [3:0] S_PWR  = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_RDW  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0]      state;
  rfr_pkg::entry_t cur;
  logic [1:0]      band;
  logic [TW-1:0]   ctop;
  logic [CW-1:0]   clip_l [CLIP_DEPTH];
  logic [HW-1:0]   clip_t [CLIP_DEPTH];
  logic [CW-1:0]   clip_r [CLIP_DEPTH];
  logic [HW-1:0]   clip_b [CLIP_DEPTH];
  logic [CW-1:0]   rl;
  logic [CW-1:0]   rr;
  logic [HW-1:0]   rt;
  logic [HW-1:0]   rb;
  logic [CW-1:0]   px;
  logic [HW-1:0]   py;
  logic [AW-1:0]   clr_addr;
  logic [16:0]     n_r;
  logic [16:0]     n_g;
  logic [16:0]     n_b;
  logic [16:0]     n_a;
  logic [31:0]     pix;
  logic [1:0]      stat;
  logic            out_valid;
  logic [31:0]     out_pixel;
  logic [1:0]      out_status;
  logic [4:0]      out_depth;

  logic signed [19:0] aw, ah;
  logic signed [19:0] bx, by, bw, bh, sw;
  logic signed [19:0] fl, ft, ce, cf;
  logic signed [19:0] l0, t0, r0, b0, l1, t1, r1, b1;
  logic signed [19:0] cl, ct, cr, cb;
  logic signed [19:0] qx, qy;
  logic               q_in;
  logic [AW-1:0]      pix_addr;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rdata;
  logic [31:0]        blended;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_wdata;
  logic [1:0]         last_band;
  logic [CW-1:0]      px_inc;
  logic [HW-1:0]      py_inc;
  logic [12:0]        dim_w;
  logic [12:0]        dim_h;
  logic [16:0]        inv_a;

  assign dim_w = rfr_pkg::act_dim(cfg.width, MAX_WIDTH);
  assign dim_h = rfr_pkg::act_dim(cfg.height, MAX_HEIGHT);
  assign aw    = 20'(dim_w);
  assign ah    = 20'(dim_h);
  assign inv_a = 17'(8'd255 - cur.alpha);

  // band geometry
  always_comb begin
    sw = 20'(cur.stroke_size);
    bx = 20'(cur.rect_x);
    by = 20'(cur.rect_y);
    bw = 20'(cur.rect_width);
    bh = 20'(cur.rect_height);
    if (cur.kind == rfr_pkg::K_STROKE) begin
      case (band)
        2'd0: bh = sw;
        2'd1: begin
          by = 20'(cur.rect_y) + 20'(cur.rect_height) - sw;
          bh = sw;
        end
        2'd2: bw = sw;
        default: begin
          bx = 20'(cur.rect_x) + 20'(cur.rect_width) - sw;
          bw = sw;
        end
      endcase
    end
  end

  always_comb begin
    fl = bx >>> 4;
    ft = by >>> 4;
    ce = (bx + bw + 20'sd15) >>> 4;
    cf = (by + bh + 20'sd15) >>> 4;
    l0 = (fl > 20'sd0) ? fl : 20'sd0;
    t0 = (ft > 20'sd0) ? ft : 20'sd0;
    r0 = (ce < aw) ? ce : aw;
    b0 = (cf < ah) ? cf : ah;
    if (r0 < l0) r0 = l0;
    if (b0 < t0) b0 = t0;
    cl = 20'(clip_l[ctop]);
    ct = 20'(clip_t[ctop]);
    cr = 20'(clip_r[ctop]);
    cb = 20'(clip_b[ctop]);
    l1 = (l0 > cl) ? l0 : cl;
    t1 = (t0 > ct) ? t0 : ct;
    r1 = (r0 < cr) ? r0 : cr;
    b1 = (b0 < cb) ? b0 : cb;
    if (r1 < l1) r1 = l1;
    if (b1 < t1) b1 = t1;
  end

  assign qx       = 20'(pop_data.rect_x);
  assign qy       = 20'(pop_data.rect_y);
  assign q_in     = (qx >= 20'sd0) && (qy >= 20'sd0) && (qx < aw) && (qy < ah);
  assign rd_addr  = AW'(AW'(qy[HW-1:0]) * AW'(MAX_WIDTH) + AW'(qx[CW-1:0]));
  assign pix_addr = AW'(AW'(py) * AW'(MAX_WIDTH) + AW'(px));
  assign last_band = (cur.kind == rfr_pkg::K_STROKE) ? 2'd3 : 2'd0;
  assign px_inc   = px + CW'(1);
  assign py_inc   = py + HW'(1);

  // exact divide by 255 for n below 65280 (255*256)
  function automatic logic [7:0] div255(input logic [16:0] n);
    logic [16:0] t;
    t = n + 17'd1 + 17'(n[16:8]);
    return t[15:8];
  endfunction

  assign blended = {div255(n_r), div255(n_g), div255(n_b), div255(n_a)};

  assign pop_ready = (state == S_IDLE);

  assign ram_we    = (state == S_PWR) || (state == S_CLR);
  assign ram_waddr = (state == S_CLR) ? clr_addr : pix_addr;
  assign ram_wdata = (state == S_CLR) ? cfg.color : blended;
  assign ram_re    = (state == S_PRD) ||
                     (pop_valid && pop_ready && pop_data.kind == rfr_pkg::K_READ && q_in);
  assign ram_raddr = (state == S_IDLE) ? rd_addr : pix_addr;

  rfr_ram #(.WIDTH(32), .DEPTH(NPIX)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ctop      <= '0;
      clip_l[0] <= '0;
      clip_t[0] <= '0;
      clip_r[0] <= CW'(rfr_pkg::act_dim(rfr_pkg::RST_IMAGE_WIDTH, MAX_WIDTH));
      clip_b[0] <= HW'(rfr_pkg::act_dim(rfr_pkg::RST_IMAGE_HEIGHT, MAX_HEIGHT));
    end else begin
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid && pop_ready) begin
            cur  <= pop_data;
            band <= 2'd0;
            pix  <= '0;
            stat <= rfr_pkg::ST_DONE;
            case (pop_data.kind)
              rfr_pkg::K_FILL, rfr_pkg::K_STROKE, rfr_pkg::K_CLIP: state <= S_RECT;
              rfr_pkg::K_SAVE: begin
                if (int'(ctop) + 1 >= CLIP_DEPTH) begin
                  stat <= rfr_pkg::ST_SAVE_FULL;
                end else begin
                  clip_l[TW'(ctop + TW'(1))] <= clip_l[ctop];
                  clip_t[TW'(ctop + TW'(1))] <= clip_t[ctop];
                  clip_r[TW'(ctop + TW'(1))] <= clip_r[ctop];
                  clip_b[TW'(ctop + TW'(1))] <= clip_b[ctop];
                  ctop <= ctop + TW'(1);
                end
                state <= S_DONE;
              end
              rfr_pkg::K_RESTORE: begin
                if (ctop != '0) ctop <= ctop - TW'(1);
                state <= S_DONE;
              end
              rfr_pkg::K_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              rfr_pkg::K_READ: begin
                if (q_in) begin
                  state <= S_RDW;
                end else begin
                  stat  <= rfr_pkg::ST_READ_OUT;
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RECT: begin
          rl <= CW'(l1);
          rr <= CW'(r1);
          rt <= HW'(t1);
          rb <= HW'(b1);
          px <= CW'(l1);
          py <= HW'(t1);
          if (cur.kind == rfr_pkg::K_CLIP) begin
            clip_l[ctop] <= CW'(l1);
            clip_t[ctop] <= HW'(t1);
            clip_r[ctop] <= CW'(r1);
            clip_b[ctop] <= HW'(b1);
            state <= S_DONE;
          end else if (l1 == r1 || t1 == b1) begin
            if (band == last_band) state <= S_DONE;
            else band <= band + 2'd1;
          end else begin
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PMUL;
        S_PMUL: begin
          n_r <= 17'(cur.red) * 17'(cur.alpha) + 17'(rdata[31:24]) * inv_a + 17'd127;
          n_g <= 17'(cur.green) * 17'(cur.alpha) + 17'(rdata[23:16]) * inv_a + 17'd127;
          n_b <= 17'(cur.blue) * 17'(cur.alpha) + 17'(rdata[15:8]) * inv_a + 17'd127;
          n_a <= 17'(8'd255) * 17'(cur.alpha) + 17'(rdata[7:0]) * inv_a + 17'd127;
          state <= S_PWR;
        end
        S_PWR: begin
          if (px_inc == rr) begin
            px <= rl;
            if (py_inc == rb) begin
              if (band == last_band) begin
                state <= S_DONE;
              end else begin
                band  <= band + 2'd1;
                state <= S_RECT;
              end
            end else begin
              py    <= py_inc;
              state <= S_PRD;
            end
          end else begin
            px    <= px_inc;
            state <= S_PRD;
          end
        end
        S_CLR: begin
          if (clr_addr == AW'(NPIX - 1)) begin
            ctop      <= '0;
            clip_l[0] <= '0;
            clip_t[0] <= '0;
            clip_r[0] <= CW'(dim_w);
            clip_b[0] <= HW'(dim_h);
            state     <= S_DONE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_RDW: begin
          pix   <= rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_pixel  <= pix;
            out_status <= stat;
            out_depth  <= 5'(int'(ctop) + 1);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.pixel_value = out_pixel;
  assign res.status      = out_status;
  assign res.clip_depth  = out_depth;

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    int'(ctop) < CLIP_DEPTH) else $error("clip top out of range");
  a_walk_in_rect: assert property (@(posedge clk) disable iff (rst)
    state == S_PRD |-> px >= rl && px < rr && py >= rt && py < rb)
    else $error("pixel walk left its rectangle");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |-> state == S_IDLE)
    else $error("word taken while busy");
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid) else $error("result not posted");
endmodule
`default_nettype wire

// File: sim/rect_fill_raster_with_clip_stack_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_raster_with_clip_stack_unit_tb
// Self-checking bench for the rectangle raster engine. A directed table
// covers clear, reads in and out of the image, opaque and transparent fills,
// odd rectangles, thin and thick strokes, a full and an emptied clip stack
// and the unused command code. Random phases follow, each with its own image
// size and clear color, with fills, strokes, stack and clip commands and pixel
// reads. A behavioral copy of the engine (frame, clip stack, registers)
// predicts every result word. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rect_fill_raster_with_clip_stack_unit_tb;

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  localparam int STACK_N = 16;

  typedef struct {
    logic [31:0] pix;
    logic [1:0]  st;
    logic [4:0]  dep;
  } res_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] x, y, w, h;
    logic [11:0] sw;
    logic [31:0] rgba;
    bit          chk;
    res_t        exp;
  } word_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  rfr_cmd_if cmd_ch ();
  rfr_res_if res_ch ();

  rect_fill_raster_with_clip_stack_unit dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted engine state
  logic [31:0] frame [FB_W*FB_H];
  int clip_l [STACK_N], clip_t [STACK_N], clip_r [STACK_N], clip_b [STACK_N];
  int stack_top;
  logic [8:0] img_w_reg, img_h_reg;
  logic [31:0] clear_rgba;

  res_t pending_results [$];
  word_t dir_tab [$];
  int errors;
  bit gaps_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int act_w();
    if (img_w_reg == 0) return 1;
    return (img_w_reg > FB_W) ? FB_W : int'(img_w_reg);
  endfunction

  function automatic int act_h();
    if (img_h_reg == 0) return 1;
    return (img_h_reg > FB_H) ? FB_H : int'(img_h_reg);
  endfunction

  function automatic int fl16(int v);
    return v >= 0 ? v / 16 : -((-v + 15) / 16);
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic void snap_rect(input int x, y, w, h, output int l, t, r, b);
    l = imax(0, fl16(x));
    t = imax(0, fl16(y));
    r = imin(act_w(), -fl16(-(x + w)));
    b = imin(act_h(), -fl16(-(y + h)));
    if (r < l) r = l;
    if (b < t) b = t;
  endfunction

  function automatic logic [7:0] mix8(int s, int d, int a);
    return 8'((s * a + d * (255 - a) + 127) / 255);
  endfunction

  function automatic void paint(int x, int y, int w, int h, logic [31:0] c);
    int l, t, r, b, py, px, k;
    logic [31:0] d;
    snap_rect(x, y, w, h, l, t, r, b);
    k = stack_top;
    l = imax(l, clip_l[k]);
    t = imax(t, clip_t[k]);
    r = imin(r, clip_r[k]);
    b = imin(b, clip_b[k]);
    for (py = t; py < b; py++)
      for (px = l; px < r; px++) begin
        d = frame[py * FB_W + px];
        frame[py * FB_W + px] = {mix8(c[31:24], d[31:24], c[7:0]),
                                 mix8(c[23:16], d[23:16], c[7:0]),
                                 mix8(c[15:8], d[15:8], c[7:0]),
                                 mix8(255, d[7:0], c[7:0])};
      end
  endfunction

  function automatic void reset_clip();
    stack_top = 0;
    clip_l[0] = 0;
    clip_t[0] = 0;
    clip_r[0] = act_w();
    clip_b[0] = act_h();
  endfunction

  function automatic res_t raster_step(word_t wd);
    res_t o;
    int x, y, w, h, s, l, t, r, b, i;
    x = int'(signed'(wd.x));
    y = int'(signed'(wd.y));
    w = int'(signed'(wd.w));
    h = int'(signed'(wd.h));
    o.pix = 0;
    o.st = rfr_pkg::ST_DONE;
    case (wd.cmd)
      rfr_pkg::CMD_FILL: paint(x, y, w, h, wd.rgba);
      rfr_pkg::CMD_STROKE: begin
        s = int'(wd.sw);
        if (s < int'(rfr_pkg::MIN_STROKE)) s = int'(rfr_pkg::MIN_STROKE);
        paint(x, y, w, s, wd.rgba);
        paint(x, y + h - s, w, s, wd.rgba);
        paint(x, y, s, h, wd.rgba);
        paint(x + w - s, y, s, h, wd.rgba);
      end
      rfr_pkg::CMD_SAVE: begin
        if (stack_top + 1 >= STACK_N) o.st = rfr_pkg::ST_SAVE_FULL;
        else begin
          clip_l[stack_top + 1] = clip_l[stack_top];
          clip_t[stack_top + 1] = clip_t[stack_top];
          clip_r[stack_top + 1] = clip_r[stack_top];
          clip_b[stack_top + 1] = clip_b[stack_top];
          stack_top++;
        end
      end
      rfr_pkg::CMD_RESTORE: if (stack_top > 0) stack_top--;
      rfr_pkg::CMD_CLIP: begin
        snap_rect(x, y, w, h, l, t, r, b);
        clip_l[stack_top] = imax(clip_l[stack_top], l);
        clip_t[stack_top] = imax(clip_t[stack_top], t);
        clip_r[stack_top] = imin(clip_r[stack_top], r);
        clip_b[stack_top] = imin(clip_b[stack_top], b);
        if (clip_r[stack_top] < clip_l[stack_top]) clip_r[stack_top] = clip_l[stack_top];
        if (clip_b[stack_top] < clip_t[stack_top]) clip_b[stack_top] = clip_t[stack_top];
      end
      rfr_pkg::CMD_CLEAR: begin
        for (i = 0; i < FB_W * FB_H; i++) frame[i] = clear_rgba;
        reset_clip();
      end
      rfr_pkg::CMD_READ: begin
        if (x < 0 || y < 0 || x >= act_w() || y >= act_h()) o.st = rfr_pkg::ST_READ_OUT;
        else o.pix = frame[y * FB_W + x];
      end
      default: ;
    endcase
    o.dep = 5'(stack_top + 1);
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_on || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic word_t mk(logic [2:0] c, int x, int y, int w, int h, int sw,
                               logic [31:0] rgba, bit chk = 0, logic [31:0] pix = 0,
                               logic [1:0] st = rfr_pkg::ST_DONE, int dep = 1);
    word_t wd;
    wd.cmd = c;
    wd.x = 16'(x);
    wd.y = 16'(y);
    wd.w = 16'(w);
    wd.h = 16'(h);
    wd.sw = 12'(sw);
    wd.rgba = rgba;
    wd.chk = chk;
    wd.exp.pix = pix;
    wd.exp.st = st;
    wd.exp.dep = 5'(dep);
    return wd;
  endfunction

  function automatic void add_row(word_t wd);
    dir_tab.insert(dir_tab.size(), wd);
  endfunction

  task automatic send(word_t wd);
    int g;
    res_t p;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      cmd_ch.valid = 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid = 1;
    cmd_ch.command = wd.cmd;
    cmd_ch.rect_x = wd.x;
    cmd_ch.rect_y = wd.y;
    cmd_ch.rect_width = wd.w;
    cmd_ch.rect_height = wd.h;
    cmd_ch.stroke_size = wd.sw;
    {cmd_ch.red, cmd_ch.green, cmd_ch.blue, cmd_ch.alpha} = wd.rgba;
    do @(posedge clk); while (!cmd_ch.ready);
    p = raster_step(wd);
    pending_results.insert(pending_results.size(), wd.chk ? wd.exp : p);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    cmd_ch.valid = 0;
  endtask

  task automatic drain();
    idle_sender();
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    case (idx)
      rfr_pkg::REG_WIDTH: img_w_reg = val[8:0];
      rfr_pkg::REG_HEIGHT: img_h_reg = val[8:0];
      rfr_pkg::REG_COLOR: clear_rgba = val;
      default: ;
    endcase
  endtask

  function automatic word_t rand_word();
    word_t wd;
    int p, aw, ah;
    aw = act_w();
    ah = act_h();
    wd = mk(rfr_pkg::CMD_FILL, 0, 0, 0, 0, 0, $urandom());
    case ($urandom_range(0, 3))
      0: wd.rgba[7:0] = 8'hFF;
      1: wd.rgba[7:0] = 8'h00;
      default: ;
    endcase
    wd.x = 16'($urandom_range(0, (aw + 8) * 16) - 64);
    wd.y = 16'($urandom_range(0, (ah + 8) * 16) - 64);
    wd.w = 16'($urandom_range(0, 24 * 16));
    wd.h = 16'($urandom_range(0, 24 * 16));
    if ($urandom_range(0, 9) == 0) wd.w = -wd.w;
    if ($urandom_range(0, 9) == 0) wd.h = -wd.h;
    wd.sw = 12'($urandom_range(0, 64));
    if ($urandom_range(0, 49) == 0) begin
      wd.x = 16'($urandom());
      wd.y = 16'($urandom());
      wd.w = 16'($urandom());
      wd.h = 16'($urandom());
    end
    p = $urandom_range(0, 99);
    if (p < 33) wd.cmd = rfr_pkg::CMD_FILL;
    else if (p < 43) begin
      wd.cmd = rfr_pkg::CMD_STROKE;
      if ($urandom_range(0, 19) == 0) begin
        wd.sw = 12'($urandom());
        wd.w = 16'($urandom_range(0, 6 * 16));
        wd.h = 16'($urandom_range(0, 6 * 16));
      end
    end
    else if (p < 54) wd.cmd = rfr_pkg::CMD_SAVE;
    else if (p < 65) wd.cmd = rfr_pkg::CMD_RESTORE;
    else if (p < 74) begin
      wd.cmd = rfr_pkg::CMD_CLIP;
      wd.w = 16'($urandom_range(0, (aw + 16) * 16));
      wd.h = 16'($urandom_range(0, (ah + 16) * 16));
    end
    else if (p < 97) begin
      wd.cmd = rfr_pkg::CMD_READ;
      if ($urandom_range(0, 15) == 0) begin
        wd.x = 16'($urandom());
        wd.y = 16'($urandom());
      end else begin
        wd.x = 16'($urandom_range(0, aw + 2) - 1);
        wd.y = 16'($urandom_range(0, ah + 2) - 1);
      end
    end
    else wd.cmd = rfr_pkg::K_NOP;
    return wd;
  endfunction

  // result side: random stalls, in-order compare
  int stall_left;
  initial begin
    res_ch.ready = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready = 0;
        stall_left--;
      end else begin
        res_ch.ready = 1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h/%0d/%0d",
                                   res_ch.pixel_value, res_ch.status, res_ch.clip_depth);
      end else begin
        e = pending_results.pop_front();
        if (res_ch.pixel_value !== e.pix || res_ch.status !== e.st ||
            res_ch.clip_depth !== e.dep) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     e.pix, e.st, e.dep, res_ch.pixel_value, res_ch.status,
                     res_ch.clip_depth);
        end
      end
    end
  end

  initial begin
    logic [8:0] ph_w [5];
    logic [8:0] ph_h [5];
    bit ph_clr [5];
    int ph, n;
    errors = 0;
    gaps_on = 1;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    cmd_ch.valid = 0;
    cmd_ch.command = rfr_pkg::CMD_FILL;
    cmd_ch.rect_x = 0;
    cmd_ch.rect_y = 0;
    cmd_ch.rect_width = 0;
    cmd_ch.rect_height = 0;
    cmd_ch.stroke_size = 0;
    cmd_ch.red = 0;
    cmd_ch.green = 0;
    cmd_ch.blue = 0;
    cmd_ch.alpha = 0;
    img_w_reg = rfr_pkg::RST_IMAGE_WIDTH;
    img_h_reg = rfr_pkg::RST_IMAGE_HEIGHT;
    clear_rgba = rfr_pkg::RST_CLEAR_COLOR;
    reset_clip();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    add_row(mk(rfr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF,
               rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_READ, -1, 5, 0, 0, 0, 0, 1, 0, rfr_pkg::ST_READ_OUT, 1));
    add_row(mk(rfr_pkg::CMD_READ, 0, 256, 0, 0, 0, 0, 1, 0, rfr_pkg::ST_READ_OUT, 1));
    add_row(mk(rfr_pkg::CMD_READ, 255, 255, 0, 0, 0, 0, 1, 32'hFFFF_FFFF,
               rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_FILL, 0, 0, 64, 64, 0, 32'h0C22_38FF, 1, 0,
               rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_READ, 1, 1, 0, 0, 0, 0, 1, 32'h0C22_38FF,
               rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_FILL, 8, 8, 32, 32, 0, 32'hFFFF_FF00));
    add_row(mk(rfr_pkg::CMD_FILL, 7, 9, 41, 23, 0, 32'h80FF_0080));
    add_row(mk(rfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    add_row(mk(rfr_pkg::CMD_FILL, -32768, 4064, 32767, 24, 0, 32'h1234_56C0));
    add_row(mk(rfr_pkg::CMD_FILL, 32767, 0, 64, 64, 0, 32'hFFFF_FFFF));
    add_row(mk(rfr_pkg::CMD_FILL, 100, 100, -32768, 80, 0, 32'hFFFF_FFFF));
    add_row(mk(rfr_pkg::CMD_STROKE, 160, 160, 160, 160, 0, 32'h00FF_0080));
    add_row(mk(rfr_pkg::CMD_STROKE, 1600, 320, 128, 128, 4095, 32'hA0B0_C040));
    add_row(mk(rfr_pkg::CMD_READ, 10, 2, 0, 0, 0, 0));
    for (int i = 0; i < 15; i++)
      add_row(mk(rfr_pkg::CMD_SAVE, 0, 0, 0, 0, 0, 0));
    add_row(mk(rfr_pkg::CMD_SAVE, 0, 0, 0, 0, 0, 0, 1, 0, rfr_pkg::ST_SAVE_FULL, 16));
    add_row(mk(rfr_pkg::CMD_CLIP, 40, 40, 320, 320, 0, 0));
    add_row(mk(rfr_pkg::CMD_FILL, 0, 0, 2000, 2000, 0, 32'h55AA_33FF));
    add_row(mk(rfr_pkg::CMD_READ, 3, 3, 0, 0, 0, 0));
    for (int i = 0; i < 15; i++)
      add_row(mk(rfr_pkg::CMD_RESTORE, 0, 0, 0, 0, 0, 0));
    add_row(mk(rfr_pkg::CMD_RESTORE, 0, 0, 0, 0, 0, 0, 1, 0, rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::K_NOP, 5, 5, 5, 5, 5, 32'hFFFF_FFFF, 1, 0, rfr_pkg::ST_DONE, 1));
    add_row(mk(rfr_pkg::CMD_CLIP, -32768, -32768, 32767, 32767, 0, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);

    ph_w = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd173};
    ph_h = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd90};
    ph_clr = '{1, 0, 1, 0, 1};
    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(rfr_pkg::REG_WIDTH, 32'(ph_w[ph]));
        write_reg(rfr_pkg::REG_HEIGHT, 32'(ph_h[ph]));
        write_reg(rfr_pkg::REG_COLOR, ph == 1 ? 32'h0 : ph == 3 ? 32'hFFFF_FFFF : $urandom());
      end
      gaps_on = (ph != 2);
      if (ph_clr[ph]) send(mk(rfr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      for (n = 0; n < 104; n++) send(rand_word());
    end
    idle_sender();
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    errors += pending_results.size();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
